// ----- rtl/core/bpc_pkg.sv -----
// Shared types and constants for the barometric compensation pipeline.
// Used by the top level of the block and by its port checker; depends on nothing.
package bpc_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } bpc_in_t;

  typedef struct packed {
    logic signed [27:0] temperature_centi_c;
    logic [31:0]        pressure_q24_8;
    logic [23:0]        pressure_pa;
    logic               pressure_valid;
  } bpc_out_t;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LAST = 2'd3;

  localparam logic [63:0] TF_OFFSET = 64'd128000;
  localparam logic [63:0] P_BASE    = 64'd1048576;
  localparam logic [63:0] P_SCALE   = 64'd3125;
  localparam logic [63:0] W1_BIAS   = 64'h0000_8000_0000_0000;

endpackage

// ----- rtl/core/bpc_mul64.sv -----
// Two-stage 64x64 multiplier, low 64 bits of the product, built from 32x32 parts.
// Several independent lanes share one side band and one valid bit; uses no package.
module bpc_mul64 #(
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [63:0]   a_i [LANES],
  input  logic [63:0]   b_i [LANES],
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [63:0]   p_o [LANES],
  output logic [SW-1:0] side_o
);

  logic [63:0]   ll_r [LANES];
  logic [31:0]   h1_r [LANES];
  logic [31:0]   h2_r [LANES];
  logic [63:0]   p_r  [LANES];
  logic [SW-1:0] side1_r;
  logic [SW-1:0] side2_r;
  logic          vld1_r;
  logic          vld2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  // The high halves only reach bits above 63 when multiplied together, so
  // the cross terms are kept to 32 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        ll_r[i] <= a_i[i][31:0] * b_i[i][31:0];
        h1_r[i] <= a_i[i][63:32] * b_i[i][31:0];
        h2_r[i] <= a_i[i][31:0] * b_i[i][63:32];
        p_r[i]  <= ll_r[i] + {h1_r[i] + h2_r[i], 32'b0};
      end
      side1_r <= side_i;
      side2_r <= side1_r;
    end
  end

  assign vld_o  = vld2_r;
  assign p_o    = p_r;
  assign side_o = side2_r;

endmodule

// ----- rtl/core/bpc_div64.sv -----
// Pipelined signed 64-bit divider, one restoring quotient bit per stage.
// Truncates toward zero and flags a zero divisor; uses no package.
module bpc_div64 #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [63:0]   dividend_i,
  input  logic [63:0]   divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [63:0]   quot_o,
  output logic          zero_o,
  output logic [SW-1:0] side_o
);

  localparam int DW = 64;

  // Index 0 holds the magnitudes, index k the state after k quotient bits.
  logic [DW-1:0] rem_r  [DW+1];
  logic [DW-1:0] dq_r   [DW+1];
  logic [DW-1:0] dv_r   [DW+1];
  logic          neg_r  [DW+1];
  logic          zero_r [DW+1];
  logic [SW-1:0] side_r [DW+1];
  logic          vld_r  [DW+1];

  logic [DW-1:0] quot_r;
  logic          zero_o_r;
  logic [SW-1:0] side_o_r;
  logic          vld_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      dq_r[0]   <= dividend_i[DW-1] ? (DW'(0) - dividend_i) : dividend_i;
      dv_r[0]   <= divisor_i[DW-1] ? (DW'(0) - divisor_i) : divisor_i;
      neg_r[0]  <= dividend_i[DW-1] ^ divisor_i[DW-1];
      zero_r[0] <= (divisor_i == '0);
      side_r[0] <= side_i;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW-1:0] sh_w;
    logic          ge_w;

    // The remainder stays below the divisor magnitude, at most 2^63, so the
    // shifted value never needs a 65th bit.
    assign sh_w = {rem_r[k][DW-2:0], dq_r[k][DW-1]};
    assign ge_w = (sh_w >= dv_r[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge_w ? (sh_w - dv_r[k]) : sh_w;
        dq_r[k+1]   <= {dq_r[k][DW-2:0], ge_w};
        dv_r[k+1]   <= dv_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else if (en) begin
      vld_o_r <= vld_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r   <= neg_r[DW] ? (DW'(0) - dq_r[DW]) : dq_r[DW];
      zero_o_r <= zero_r[DW];
      side_o_r <= side_r[DW];
    end
  end

  assign vld_o  = vld_o_r;
  assign quot_o = quot_r;
  assign zero_o = zero_o_r;
  assign side_o = side_o_r;

endmodule

// ----- rtl/core/baro_temp_pressure_compensation.sv -----
// Top level of the barometric temperature and pressure compensation pipeline.
// Depends on bpc_pkg, bpc_mul64 and bpc_div64.
//
//   channel  ports                              beat
//   in       in_valid, in_stall, in_data        raw temperature and pressure pair
//   out      out_valid, out_stall, out_data     compensated temperature and pressure
//   cfg      cfg_we, cfg_index, cfg_wdata       one calibration register write
//
// One beat enters per cycle while in_stall is low.
// Most of the depth lies in the 64 one-bit stages of the pressure divider.
// rst_n is synchronous and clears the valid bits and the calibration registers.
// A stall while a result is shown freezes the whole pipeline in the same cycle, so in_stall
// follows out_stall while a result waits.
module baro_temp_pressure_compensation (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bpc_pkg::bpc_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bpc_pkg::bpc_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import bpc_pkg::*;

  typedef struct packed {
    logic [27:0] temp;
    logic [19:0] adp;
  } sd_a_t;

  typedef struct packed {
    sd_a_t       base;
    logic [63:0] a5;
    logic [63:0] a2;
  } sd_b_t;

  typedef struct packed {
    sd_a_t       base;
    logic [63:0] w2;
  } sd_c_t;

  typedef struct packed {
    logic [27:0] temp;
    logic [63:0] w1f;
  } sd_f_t;

  typedef struct packed {
    logic        pv;
    logic [27:0] temp;
    logic [63:0] p;
  } sd_p_t;

  typedef struct packed {
    sd_p_t       base;
    logic [63:0] r8;
  } sd_q_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned s);
    return 64'($signed(v) >>> s);
  endfunction

  logic en;
  logic out_valid_r;

  // Calibration registers.
  logic [47:0] cal_t_r;
  logic [63:0] cal_pl_r;
  logic [63:0] cal_ph_r;
  logic [15:0] cal_p9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t_r  <= '0;
      cal_pl_r <= '0;
      cal_ph_r <= '0;
      cal_p9_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMP:       cal_t_r  <= cfg_wdata[47:0];
        CFG_PRESS_LOW:  cal_pl_r <= cfg_wdata;
        CFG_PRESS_HIGH: cal_ph_r <= cfg_wdata;
        CFG_PRESS_LAST: cal_p9_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = cal_t_r[15:0];
  assign t2 = {{16{cal_t_r[31]}}, cal_t_r[31:16]};
  assign t3 = {{16{cal_t_r[47]}}, cal_t_r[47:32]};
  assign p1 = {48'b0, cal_pl_r[15:0]};
  assign p2 = sx16(cal_pl_r[31:16]);
  assign p3 = sx16(cal_pl_r[47:32]);
  assign p4 = sx16(cal_pl_r[63:48]);
  assign p5 = sx16(cal_ph_r[15:0]);
  assign p6 = sx16(cal_ph_r[31:16]);
  assign p7 = sx16(cal_ph_r[47:32]);
  assign p8 = sx16(cal_ph_r[63:48]);
  assign p9 = sx16(cal_p9_r);

  // The pipeline moves as one unless a finished result is being held.
  assign in_stall = out_valid_r & out_stall;
  assign en       = ~in_stall;

  // Fine temperature in 32-bit arithmetic, stages s1 to s5.
  logic        s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic [19:0] s1_adt_r, s1_adp_r, s2_adp_r, s3_adp_r, s4_adp_r;
  logic [31:0] s2_m1_r, s2_m2_r, s3_v1_r, s3_m3_r, s4_tf_r;
  sd_a_t       s5_r;
  logic [63:0] s5_w1_r;

  logic [31:0] s2_a_nxt, s2_b_nxt, s5_temp_nxt;

  assign s2_a_nxt    = ({12'b0, s1_adt_r} >> 3) - {15'b0, t1, 1'b0};
  assign s2_b_nxt    = ({12'b0, s1_adt_r} >> 4) - {16'b0, t1};
  assign s5_temp_nxt = 32'($signed(s4_tf_r * 32'd5 + 32'd128) >>> 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_adt_r <= in_data.raw_temperature;
      s1_adp_r <= in_data.raw_pressure;
      s2_m1_r  <= s2_a_nxt * t2;
      s2_m2_r  <= s2_b_nxt * s2_b_nxt;
      s2_adp_r <= s1_adp_r;
      s3_v1_r  <= 32'($signed(s2_m1_r) >>> 11);
      s3_m3_r  <= 32'($signed(s2_m2_r) >>> 12) * t3;
      s3_adp_r <= s2_adp_r;
      s4_tf_r  <= s3_v1_r + 32'($signed(s3_m3_r) >>> 14);
      s4_adp_r <= s3_adp_r;
      s5_r.temp <= s5_temp_nxt[27:0];
      s5_r.adp  <= s4_adp_r;
      s5_w1_r  <= {{32{s4_tf_r[31]}}, s4_tf_r} - TF_OFFSET;
    end
  end

  // First product layer: w1*w1, w1*P5, w1*P2.
  logic [63:0] m1_a [3];
  logic [63:0] m1_b [3];
  logic [63:0] m1_p [3];
  logic        m1_v;
  sd_a_t       m1_side;

  assign m1_a[0] = s5_w1_r;
  assign m1_a[1] = s5_w1_r;
  assign m1_a[2] = s5_w1_r;
  assign m1_b[0] = s5_w1_r;
  assign m1_b[1] = p5;
  assign m1_b[2] = p2;

  bpc_mul64 #(.LANES(3), .SW($bits(sd_a_t))) u_mul1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(s5_v_r), .a_i(m1_a), .b_i(m1_b), .side_i(s5_r),
    .vld_o(m1_v), .p_o(m1_p), .side_o(m1_side)
  );

  // Second layer: w1*w1*P6 and w1*w1*P3.
  logic [63:0] m2_a [2];
  logic [63:0] m2_b [2];
  logic [63:0] m2_p [2];
  logic        m2_v;
  sd_b_t       m2_side_in, m2_side;

  assign m2_a[0] = m1_p[0];
  assign m2_a[1] = m1_p[0];
  assign m2_b[0] = p6;
  assign m2_b[1] = p3;
  assign m2_side_in.base = m1_side;
  assign m2_side_in.a5   = m1_p[1];
  assign m2_side_in.a2   = m1_p[2];

  bpc_mul64 #(.LANES(2), .SW($bits(sd_b_t))) u_mul2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(m1_v), .a_i(m2_a), .b_i(m2_b), .side_i(m2_side_in),
    .vld_o(m2_v), .p_o(m2_p), .side_o(m2_side)
  );

  // w2 and the biased divisor term.
  logic        s6_v_r;
  sd_a_t       s6_r;
  logic [63:0] s6_w2_r, s6_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_r    <= m2_side.base;
      s6_w2_r <= m2_p[0] + (m2_side.a5 << 17) + (p4 << 35);
      s6_s_r  <= W1_BIAS + asr64(m2_p[1], 8) + (m2_side.a2 << 12);
    end
  end

  logic [63:0] m3_a [1];
  logic [63:0] m3_b [1];
  logic [63:0] m3_p [1];
  logic        m3_v;
  sd_c_t       m3_side_in, m3_side;

  assign m3_a[0] = s6_s_r;
  assign m3_b[0] = p1;
  assign m3_side_in.base = s6_r;
  assign m3_side_in.w2   = s6_w2_r;

  bpc_mul64 #(.LANES(1), .SW($bits(sd_c_t))) u_mul3 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(s6_v_r), .a_i(m3_a), .b_i(m3_b), .side_i(m3_side_in),
    .vld_o(m3_v), .p_o(m3_p), .side_o(m3_side)
  );

  // Divisor and unscaled numerator.
  logic        s7_v_r;
  logic [27:0] s7_temp_r;
  logic [63:0] s7_w1f_r, s7_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_temp_r <= m3_side.base.temp;
      s7_w1f_r  <= asr64(m3_p[0], 33);
      s7_num_r  <= ((P_BASE - {44'b0, m3_side.base.adp}) << 31) - m3_side.w2;
    end
  end

  logic [63:0] m4_a [1];
  logic [63:0] m4_b [1];
  logic [63:0] m4_p [1];
  logic        m4_v;
  sd_f_t       m4_side_in, m4_side;

  assign m4_a[0] = s7_num_r;
  assign m4_b[0] = P_SCALE;
  assign m4_side_in.temp = s7_temp_r;
  assign m4_side_in.w1f  = s7_w1f_r;

  bpc_mul64 #(.LANES(1), .SW($bits(sd_f_t))) u_mul4 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(s7_v_r), .a_i(m4_a), .b_i(m4_b), .side_i(m4_side_in),
    .vld_o(m4_v), .p_o(m4_p), .side_o(m4_side)
  );

  logic        dv_v;
  logic [63:0] dv_q;
  logic        dv_zero;
  logic [27:0] dv_temp;

  bpc_div64 #(.SW(28)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(m4_v), .dividend_i(m4_p[0]), .divisor_i(m4_side.w1f), .side_i(m4_side.temp),
    .vld_o(dv_v), .quot_o(dv_q), .zero_o(dv_zero), .side_o(dv_temp)
  );

  // Correction terms: (p>>13)^2 and P8*p.
  logic [63:0] m5_a [2];
  logic [63:0] m5_b [2];
  logic [63:0] m5_p [2];
  logic        m5_v;
  sd_p_t       m5_side_in, m5_side;

  assign m5_a[0] = asr64(dv_q, 13);
  assign m5_b[0] = asr64(dv_q, 13);
  assign m5_a[1] = dv_q;
  assign m5_b[1] = p8;
  assign m5_side_in.pv   = ~dv_zero;
  assign m5_side_in.temp = dv_temp;
  assign m5_side_in.p    = dv_q;

  bpc_mul64 #(.LANES(2), .SW($bits(sd_p_t))) u_mul5 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(dv_v), .a_i(m5_a), .b_i(m5_b), .side_i(m5_side_in),
    .vld_o(m5_v), .p_o(m5_p), .side_o(m5_side)
  );

  logic [63:0] m6_a [1];
  logic [63:0] m6_b [1];
  logic [63:0] m6_p [1];
  logic        m6_v;
  sd_q_t       m6_side_in, m6_side;

  assign m6_a[0] = m5_p[0];
  assign m6_b[0] = p9;
  assign m6_side_in.base = m5_side;
  assign m6_side_in.r8   = m5_p[1];

  bpc_mul64 #(.LANES(1), .SW($bits(sd_q_t))) u_mul6 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(m5_v), .a_i(m6_a), .b_i(m6_b), .side_i(m6_side_in),
    .vld_o(m6_v), .p_o(m6_p), .side_o(m6_side)
  );

  logic        s8_v_r;
  logic        s8_pv_r;
  logic [27:0] s8_temp_r;
  logic [63:0] s8_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (en) begin
      s8_v_r <= m6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_pv_r   <= m6_side.base.pv;
      s8_temp_r <= m6_side.base.temp;
      s8_sum_r  <= m6_side.base.p + asr64(m6_p[0], 25) + asr64(m6_side.r8, 19);
    end
  end

  // Output register.
  bpc_out_t    out_data_r;
  logic [63:0] res_nxt;
  logic [31:0] q24_nxt;

  assign res_nxt = asr64(s8_sum_r, 8) + (p7 << 4);
  assign q24_nxt = s8_pv_r ? res_nxt[31:0] : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.temperature_centi_c <= s8_temp_r;
      out_data_r.pressure_q24_8      <= q24_nxt;
      out_data_r.pressure_pa         <= q24_nxt[31:8];
      out_data_r.pressure_valid      <= s8_pv_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/bpc_chk.sv -----
// Port-level checker for the compensation pipeline, bound to the top level.
// Depends on bpc_pkg for the result beat type.
module bpc_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bpc_pkg::bpc_out_t   out_data
);

  import bpc_pkg::*;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  // The input side stalls exactly while a result is held back.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the held result");

  // A held result stays on the port.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // A zero divisor gives zero pressure.
  a_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pressure_valid |->
      out_data.pressure_q24_8 == 32'd0 && out_data.pressure_pa == 24'd0)
    else $error("pressure not cleared on zero divisor");

  // Whole pascals are the Q24.8 value without its fraction.
  a_pa_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pressure_pa == out_data.pressure_q24_8[31:8])
    else $error("pressure_pa disagrees with pressure_q24_8");

endmodule

bind baro_temp_pressure_compensation bpc_chk u_bpc_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data(out_data)
);
